// ----- rtl/core/rotary_sequence_recorder_core_assert.svh -----
// Assertion macros used by the checker file of the rotary sequence recorder.
`ifndef ROTARY_SEQUENCE_RECORDER_CORE_ASSERT_SVH
`define ROTARY_SEQUENCE_RECORDER_CORE_ASSERT_SVH

// Condition in the same cycle.
`define RSR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition in the following cycle.
`define RSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rsr_pkg.sv -----
// Types and constants shared by the rotary sequence recorder modules.
package rsr_pkg;

  localparam int unsigned MaxTicksW = 7;
  localparam int unsigned TicksW    = 8;
  localparam int unsigned SegW      = 8;
  localparam int unsigned IndexW    = 3;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  localparam logic [MaxTicksW-1:0] MaxTicksReset = 7'd99;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ROTATE = 2'd0;
  localparam action_t ACT_BUTTON = 2'd1;
  localparam action_t ACT_FINAL  = 2'd2;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE  = 2'b00;
  localparam dir_t DIR_RIGHT = 2'b01;
  localparam dir_t DIR_LEFT  = 2'b11;

  typedef logic signed [SegW-1:0] seg_t;

endpackage

// ----- rtl/core/rsr_seg_mem.sv -----
// Segment store: single write port, single read port with registered read data.
module rsr_seg_mem import rsr_pkg::*; #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  seg_t             wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output seg_t             rd_data
);

  seg_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/rotary_sequence_recorder_core.sv -----
// Rotary sequence recorder: turns knob ticks into signed run lengths held in a segment memory.
// Every rotate, button and unused item gives one status transaction, registered in the cycle
// after acceptance; the input is taken again as soon as the output register is free, so such
// items run at one per cycle while the output side keeps up. A finalize that succeeds gives one
// transaction per stored segment; each segment is read from the segment memory in S_READ and
// registered in S_EMIT, and the input is held off until the last segment is registered.
// The segment memory needs no clearing after reset: only entries below the segment count are
// ever read. max_ticks is written through cfg_wr_en/cfg_wr_data and resets to 99.
module rotary_sequence_recorder_core import rsr_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [MaxTicksW-1:0] cfg_wr_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InDataW-1:0]   s_tdata,   // [1:0] direction, [7:2] zero
  input  logic [1:0]           s_tuser,   // [1:0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata,   // [7:0] segment_value, [10:8] segment_index,
                                          // [11] overflowed, [12] recording, [15:13] zero
  output logic                 m_tuser,   // [0] success
  output logic                 m_tlast
);

  localparam int unsigned CntW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AddrW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEGMENTS);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t               state;
  logic [MaxTicksW-1:0] max_ticks;
  logic                 active;
  dir_t                 run_dir;
  logic [TicksW-1:0]    run_ticks;
  logic [CntW-1:0]      seg_count;
  logic                 ovf;
  logic [CntW-1:0]      emit_idx;
  logic [CntW-1:0]      emit_n;
  logic                 emit_ovf;

  logic                 active_next;
  dir_t                 run_dir_next;
  logic [TicksW-1:0]    run_ticks_next;
  logic [CntW-1:0]      seg_count_next;
  logic                 ovf_next;

  action_t              act;
  dir_t                 din;
  logic                 accept, out_free, out_load;
  logic                 is_rot, do_close, closeable, room, fits, close_ok, close_fail;
  dir_t                 dir_c;
  logic [TicksW-1:0]    ticks_c, lim;
  logic [CntW-1:0]      cnt_c;
  logic                 ovf_c, fin_ovf, fin_ok, status_ovf;
  seg_t                 wr_data, rd_data;
  logic                 rd_en;
  logic                 emit_last;

  assign act      = s_tuser;
  assign din      = s_tdata[1:0];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign lim      = {1'b0, max_ticks};

  // A successful finalize raises no result at acceptance; its segments follow later.
  assign out_load = (accept && !((act == ACT_FINAL) && active && fin_ok)) ||
                    ((state == S_EMIT) && out_free);

  // Closing of the pending run, shared by direction change, button and finalize.
  always_comb begin
    is_rot     = (act == ACT_ROTATE) && ((din == DIR_RIGHT) || (din == DIR_LEFT));
    do_close   = (is_rot && (run_dir != DIR_NONE) && (din != run_dir)) ||
                 (((act == ACT_BUTTON) || (act == ACT_FINAL)) && active);
    closeable  = (run_dir != DIR_NONE) && (run_ticks != '0);
    room       = seg_count < MaxCnt;
    fits       = run_ticks <= lim;
    close_ok   = do_close && closeable && room && fits;
    close_fail = do_close && closeable && !(room && fits);
    dir_c      = close_ok ? DIR_NONE : run_dir;
    ticks_c    = close_ok ? '0 : run_ticks;
    cnt_c      = seg_count + CntW'(close_ok);
    ovf_c      = ovf || close_fail;
    wr_data    = run_dir[1] ? seg_t'(-run_ticks) : seg_t'(run_ticks);
    fin_ovf    = ovf_c || ((dir_c != DIR_NONE) && (ticks_c != '0) && (cnt_c >= MaxCnt));
    fin_ok     = !ovf_c && (cnt_c != '0);
  end

  // Next values of the scalar state for a non-finalize item.
  always_comb begin
    active_next    = active;
    run_dir_next   = run_dir;
    run_ticks_next = run_ticks;
    seg_count_next = seg_count;
    ovf_next       = ovf;
    if (is_rot) begin
      active_next    = 1'b1;
      run_dir_next   = din;
      run_ticks_next = (ticks_c <= lim) ? ticks_c + TicksW'(1) : ticks_c;
      seg_count_next = cnt_c;
      ovf_next       = ovf_c || (run_ticks_next > lim);
    end else if (act == ACT_BUTTON && active) begin
      run_dir_next   = dir_c;
      run_ticks_next = ticks_c;
      seg_count_next = cnt_c;
      ovf_next       = ovf_c;
    end
    status_ovf = active_next && (ovf_next ||
                 ((run_dir_next != DIR_NONE) && (run_ticks_next != '0) &&
                  (seg_count_next >= MaxCnt)));
  end

  assign rd_en     = (state == S_READ);
  assign emit_last = (emit_idx + CntW'(1)) == emit_n;

  rsr_seg_mem #(
    .Depth (MAX_SEGMENTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && close_ok),
    .wr_addr (seg_count[AddrW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (emit_idx[AddrW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_ticks <= MaxTicksReset;
      active    <= 1'b0;
      run_dir   <= DIR_NONE;
      run_ticks <= '0;
      seg_count <= '0;
      ovf       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_ticks <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            m_tuser <= 1'b0;
            m_tlast <= 1'b1;
            if (act == ACT_FINAL) begin
              m_tdata <= {4'b0000, active && fin_ovf, 11'd0};
              if (active) begin
                // The recording state is cleared now; on success the segment count lives on in emit_n.
                active    <= 1'b0;
                run_dir   <= DIR_NONE;
                run_ticks <= '0;
                seg_count <= '0;
                ovf       <= 1'b0;
                if (fin_ok) begin
                  emit_idx <= '0;
                  emit_n   <= cnt_c;
                  emit_ovf <= fin_ovf;
                  state    <= S_READ;
                end
              end
            end else begin
              active    <= active_next;
              run_dir   <= run_dir_next;
              run_ticks <= run_ticks_next;
              seg_count <= seg_count_next;
              ovf       <= ovf_next;
              m_tdata   <= {3'b000, active_next, status_ovf, 11'd0};
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tuser  <= 1'b1;
            m_tlast  <= emit_last;
            m_tdata  <= {3'b000, 1'b0, emit_ovf, IndexW'(emit_idx), rd_data};
            emit_idx <= emit_idx + CntW'(1);
            state    <= emit_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/rsr_checker.sv -----
// Port-level checker for the rotary sequence recorder, bound to the top level.
`include "rotary_sequence_recorder_core_assert.svh"

module rsr_checker import rsr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  // A stalled result keeps its contents.
  `RSR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")

  // Segments of a successful finalize never report an attempt in progress.
  `RSR_ASSERT_NOW(a_seg_not_rec, clk, rst, m_tvalid && m_tuser,
                  !m_tdata[12], "segment result shows recording")

  // A status or failure result carries no segment and always ends its transaction group.
  `RSR_ASSERT_NOW(a_status_form, clk, rst, m_tvalid && !m_tuser,
                  (m_tdata[10:0] == 11'd0) && m_tlast, "malformed status result")

  // A segment that is not the last of its run is never followed at once by a status result.
  `RSR_ASSERT_NEXT(a_last_seg_gap, clk, rst, m_tvalid && m_tready && m_tuser && !m_tlast,
                   !(m_tvalid && !m_tuser), "status result inside a segment run")

endmodule

bind rotary_sequence_recorder_core rsr_checker u_rsr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- tb/sv/rotary_sequence_recorder_core_tb.sv -----
// Self-checking testbench for the rotary sequence recorder core.
`timescale 1ns / 1ps

module rotary_sequence_recorder_core_tb;
  import rsr_pkg::*;

  localparam int unsigned SegSlots    = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 4000;

  localparam action_t ActUnused = 2'd3;
  localparam dir_t    DirBad    = 2'b10;

  typedef struct packed {
    action_t action;
    dir_t    dir;
  } knob_item_t;

  typedef struct {
    bit                success;
    seg_t              value;
    logic [IndexW-1:0] index;
    bit                last;
    bit                ovf;
    bit                rec;
  } knob_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [MaxTicksW-1:0] cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  // Gesture items waiting to be offered, and the results they are expected to give.
  knob_item_t   gesture_q[$];
  knob_result_t status_q[$];

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 63;
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned settings_done = 0;
  int unsigned stall_cycles = 0;

  // Mirror of the recorder state.
  logic [MaxTicksW-1:0] lim_ticks = MaxTicksReset;
  bit                   rec_active = 1'b0;
  dir_t                 rec_dir = DIR_NONE;
  logic [TicksW-1:0]    rec_ticks = '0;
  int unsigned          rec_count = 0;
  seg_t                 rec_mem[SegSlots];
  bit                   rec_ovf = 1'b0;

  rotary_sequence_recorder_core #(
    .MAX_SEGMENTS(SegSlots)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic void push_status(bit ok, seg_t value, int unsigned index, bit last,
                                      bit ovf, bit rec);
    knob_result_t r;
    r.success = ok;
    r.value   = value;
    r.index   = index[IndexW-1:0];
    r.last    = last;
    r.ovf     = ovf;
    r.rec     = rec;
    status_q.push_back(r);
  endfunction

  function automatic void close_pending_run();
    if (rec_dir == DIR_NONE || rec_ticks == 0) return;
    if (rec_count >= SegSlots || rec_ticks > lim_ticks) begin
      rec_ovf = 1'b1;
      return;
    end
    rec_mem[rec_count] = (rec_dir == DIR_RIGHT) ? seg_t'(rec_ticks) : -seg_t'(rec_ticks);
    rec_count++;
    rec_ticks = '0;
    rec_dir   = DIR_NONE;
  endfunction

  function automatic bit overflow_now();
    if (!rec_active) return 1'b0;
    if (rec_ovf) return 1'b1;
    return rec_dir != DIR_NONE && rec_ticks > 0 && rec_count >= SegSlots;
  endfunction

  function automatic void clear_recording();
    rec_active = 1'b0;
    rec_dir    = DIR_NONE;
    rec_ticks  = '0;
    rec_count  = 0;
    rec_ovf    = 1'b0;
  endfunction

  // Works out the transactions that one accepted item causes.
  function automatic void predict_gesture(action_t act, dir_t d);
    bit ovf;
    int unsigned n;
    if (act == ACT_FINAL) begin
      if (!rec_active) begin
        push_status(1'b0, '0, 0, 1'b1, 1'b0, 1'b0);
        return;
      end
      close_pending_run();
      ovf = overflow_now();
      if (rec_ovf || rec_count == 0) begin
        push_status(1'b0, '0, 0, 1'b1, ovf, 1'b0);
      end else begin
        n = rec_count;
        for (int unsigned i = 0; i < n; i++) begin
          push_status(1'b1, rec_mem[i], i, i + 1 == n, ovf, 1'b0);
        end
      end
      clear_recording();
      return;
    end
    if (act == ACT_ROTATE) begin
      if (d == DIR_RIGHT || d == DIR_LEFT) begin
        rec_active = 1'b1;
        if (rec_dir != DIR_NONE && d != rec_dir) close_pending_run();
        rec_dir = d;
        if (rec_ticks <= lim_ticks) rec_ticks++;
        if (rec_ticks > lim_ticks) rec_ovf = 1'b1;
      end
    end else if (act == ACT_BUTTON) begin
      if (rec_active) close_pending_run();
    end
    push_status(1'b0, '0, 0, 1'b1, overflow_now(), rec_active);
  endfunction

  // Sender: offers queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    knob_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_gesture(s_tuser, s_tdata[1:0]);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gesture_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = gesture_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.action;
          s_tdata  <= {{(InDataW-2){1'b0}}, it.dir};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= HoldCycles;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Monitor: every output transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    knob_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
        err_count++;
      end else begin
        e = status_q.pop_front();
        check_field("success", e.success, m_tuser);
        check_field("segment_value", int'(e.value), int'($signed(m_tdata[7:0])));
        check_field("segment_index", e.index, m_tdata[10:8]);
        check_field("last", e.last, m_tlast);
        check_field("overflowed", e.ovf, m_tdata[11]);
        check_field("recording", e.rec, m_tdata[12]);
      end
    end
  end

  // Watchdog: gives up when work is pending and nothing moves for too long.
  always @(posedge clk) begin
    if (!rst && (gesture_q.size() != 0 || s_tvalid || status_q.size() != 0) &&
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, stall_cycles, status_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void add_item(action_t act, dir_t d);
    knob_item_t it;
    it.action = act;
    it.dir    = d;
    gesture_q.push_back(it);
  endfunction

  task automatic set_max_ticks(logic [MaxTicksW-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    lim_ticks = v;
    settings_done++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the block empty out completely before anything else happens.
  task automatic wait_drained();
    while (gesture_q.size() != 0 || s_tvalid || status_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed gestures ending in a finalize, with some noise mixed in.
  task automatic add_random(int unsigned n_items);
    int unsigned start_len, nruns, len, r, cap;
    dir_t d;
    start_len = gesture_q.size();
    while (gesture_q.size() - start_len < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        add_item(action_t'($urandom_range(0, 3)), dir_t'($urandom_range(0, 3)));
        continue;
      end
      nruns = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
      d = $urandom_range(0, 1) ? DIR_RIGHT : DIR_LEFT;
      for (int unsigned i = 0; i < nruns; i++) begin
        r = $urandom_range(0, 19);
        cap = (lim_ticks == 0) ? 2 : ((lim_ticks >= 4) ? 4 : lim_ticks);
        if (lim_ticks <= 20 && r == 0) len = lim_ticks + 1;
        else if (lim_ticks <= 20 && r == 1 && lim_ticks != 0) len = lim_ticks;
        else len = $urandom_range(1, cap);
        for (int unsigned j = 0; j < len; j++) add_item(ACT_ROTATE, d);
        if ($urandom_range(0, 19) == 0)
          add_item(action_t'($urandom_range(0, 3)), dir_t'($urandom_range(0, 3)));
        r = $urandom_range(0, 9);
        if (r < 4) add_item(ACT_BUTTON, dir_t'($urandom_range(0, 3)));
        if (r >= 2) d = (d == DIR_RIGHT) ? DIR_LEFT : DIR_RIGHT;
      end
      if ($urandom_range(0, 3) == 0) add_item(ACT_BUTTON, dir_t'($urandom_range(0, 3)));
      if ($urandom_range(0, 19) != 0) add_item(ACT_FINAL, dir_t'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset limit of 99.
    add_item(ACT_FINAL, DIR_NONE);     // finalize with no attempt
    add_item(ACT_BUTTON, DIR_RIGHT);   // button with no attempt
    add_item(ActUnused, DIR_RIGHT);    // unused action
    add_item(ACT_ROTATE, DIR_NONE);    // direction zero is ignored
    add_item(ACT_ROTATE, DirBad);      // so is minus two
    add_item(ACT_ROTATE, DIR_RIGHT);
    add_item(ACT_ROTATE, DIR_RIGHT);
    add_item(ACT_ROTATE, DIR_LEFT);    // direction change closes the run
    add_item(ACT_ROTATE, DIR_LEFT);
    add_item(ACT_BUTTON, DIR_LEFT);
    add_item(ACT_ROTATE, DIR_RIGHT);
    add_item(ActUnused, DIR_LEFT);
    add_item(ACT_ROTATE, DIR_NONE);
    add_item(ACT_FINAL, DIR_RIGHT);
    add_item(ACT_ROTATE, DIR_LEFT);
    add_item(ACT_BUTTON, DIR_NONE);
    add_item(ACT_BUTTON, DIR_NONE);    // button with no pending run
    add_item(ACT_FINAL, DirBad);
    // Nine runs against eight slots: the last one cannot fit.
    for (int i = 0; i < 9; i++) add_item(ACT_ROTATE, (i % 2 == 0) ? DIR_RIGHT : DIR_LEFT);
    add_item(ACT_FINAL, DIR_LEFT);
    wait_drained();

    set_max_ticks(7'd3);
    add_random(70);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 28;
    set_max_ticks(7'd0);
    add_random(40);
    wait_drained();

    set_max_ticks(7'd127);
    for (int i = 0; i < 127; i++) add_item(ACT_ROTATE, DIR_LEFT);
    add_item(ACT_BUTTON, DIR_NONE);
    add_item(ACT_FINAL, DIR_NONE);
    add_random(30);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_max_ticks(7'd1);
    add_random(50);
    // The output side stalls while the sender keeps offering.
    hold_reqs++;
    wait_drained();

    set_max_ticks(MaxTicksW'($urandom_range(2, 20)));
    add_random(60);
    wait_drained();

    set_max_ticks(MaxTicksReset);
    add_random(40);
    wait_drained();

    $display("Covered %0d input items and %0d output transactions over %0d limit settings,",
             items_sent, results_seen, settings_done + 1);
    $display("including zero and full-scale limits, store overflow and a long output stall.");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
